/* rtl/msg_pkg.sv */
// msg_pkg: payload types and fixed constants of the scroll glide block
// no dependencies
package msg_pkg;

    typedef struct packed {
        logic              action;
        logic signed [31:0] amount;
        logic [15:0]       gap_ticks;
        logic              first_event;
    } in_t;

    typedef struct packed {
        logic signed [31:0] paid;
        logic              active;
    } out_t;

    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [1:0] REG_DURATION = 2'd0;
    localparam logic [1:0] REG_KINETIC  = 2'd1;
    localparam logic [1:0] REG_RECEIVED = 2'd2;

    localparam logic [15:0] DURATION_RST = 16'd1000;
    localparam logic [7:0]  KINETIC_RST  = 8'd12;
    localparam logic [9:0]  RECEIVED_RST = 10'd120;

endpackage

/* rtl/msg_ram.sv */
// msg_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module msg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/momentum_scroll_glide.sv */
// momentum_scroll_glide: wheel scroll smoother with pending glide table
// depends on msg_pkg and msg_ram
//
// Usage: input beats on in_valid/in_stall carry either a feed (action 0) or a
// tick (action 1). A feed scales the wheel amount by the keep factor through
// the shared serial divider and stores it in the table, or adds it to the due
// sum. A feed gives no output beat. A tick walks all pending entries one by
// one: one RAM read, a serial divide per entry (skipped when the entry has at
// most one tick left), and a write back that compacts the table. Each tick
// ends with one output beat (paid, active) in an output register; a new
// input beat is taken while that beat waits, but the next tick cannot finish
// until the receiver has taken it. in_stall is high while a beat is in work.
// The user must write configuration over the APB port only while the block
// is idle; the block itself does not enforce this. pready is always high.
// Reset empties the table and the due sum and loads the register defaults.
module momentum_scroll_glide
    import msg_pkg::*;
#(
    parameter int ENTRIES           = 256,
    parameter int SLOW_WINDOW_TICKS = 400
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int S_W   = 10 + $clog2(SLOW_WINDOW_TICKS + 1);
    localparam int NUM_W = S_W + 9;
    localparam int ACC_W = 32 + CW + 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SC1   = 4'd1;
    localparam logic [3:0] ST_SC2   = 4'd2;
    localparam logic [3:0] ST_SC3   = 4'd3;
    localparam logic [3:0] ST_DIVF  = 4'd4;
    localparam logic [3:0] ST_RD    = 4'd5;
    localparam logic [3:0] ST_EVAL  = 4'd6;
    localparam logic [3:0] ST_DIVT  = 4'd7;
    localparam logic [3:0] ST_APPLY = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    // configuration
    logic [15:0] dur_reg;
    logic [7:0]  kin_reg;
    logic [9:0]  rcv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= DURATION_RST;
            kin_reg <= KINETIC_RST;
            rcv_reg <= RECEIVED_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_DURATION: dur_reg <= pwdata[15:0];
                REG_KINETIC:  kin_reg <= pwdata[7:0];
                REG_RECEIVED: rcv_reg <= pwdata[9:0];
                default:      ;
            endcase
        end
    end

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_DURATION: prdata = {16'd0, dur_reg};
            REG_KINETIC:  prdata = {24'd0, kin_reg};
            REG_RECEIVED: prdata = {22'd0, rcv_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // control and datapath registers
    logic [3:0]              st_reg, st_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           w_reg, w_next;
    logic signed [31:0]      due_reg, due_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    ov_reg, ov_next;
    out_t                    od_reg, od_next;

    in_t                     it_reg, it_next;
    logic [S_W-1:0]          s_reg, s_next;
    logic [22:0]             g_reg, g_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [NUM_W-1:0]        den_reg, den_next;
    logic signed [31:0]      a_reg, a_next;
    logic [15:0]             age_reg, age_next;
    logic signed [31:0]      pay_reg, pay_next;

    // serial divider, one quotient bit a cycle
    logic [63:0]             dn_reg, dn_next;
    logic [31:0]             dd_reg, dd_next;
    logic [31:0]             dr_reg, dr_next;
    logic [31:0]             dq_reg, dq_next;
    logic [6:0]              dc_reg, dc_next;
    logic                    dneg_reg, dneg_next;

    // ram
    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [47:0]             ram_wdata, ram_rdata;

    msg_ram #(
        .WIDTH (48),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [32:0]        dv_sh;
    logic [32:0]        dv_diff;
    logic signed [31:0] dv_quot;
    logic [31:0]        t1, t2;
    logic signed [63:0] prod;
    logic [63:0]        pmag;
    logic [31:0]        amag;
    logic signed [16:0] left;
    logic signed [32:0] due_sum;
    logic signed [31:0] rest;
    logic [16:0]        age1;
    logic signed [ACC_W-1:0] acc_add;

    assign in_stall  = (st_reg != ST_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        i_next    = i_reg;
        w_next    = w_reg;
        due_next  = due_reg;
        acc_next  = acc_reg;
        ov_next   = ov_reg;
        od_next   = od_reg;
        it_next   = it_reg;
        s_next    = s_reg;
        g_next    = g_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        a_next    = a_reg;
        age_next  = age_reg;
        pay_next  = pay_reg;
        dn_next   = dn_reg;
        dd_next   = dd_reg;
        dr_next   = dr_reg;
        dq_next   = dq_reg;
        dc_next   = dc_reg;
        dneg_next = dneg_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = w_reg[AW-1:0];
        ram_raddr = i_reg[AW-1:0];

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        dv_sh   = {dr_reg, dn_reg[63]};
        dv_diff = dv_sh - {1'b0, dd_reg};
        dv_quot = dneg_reg ? -$signed(dq_reg) : $signed(dq_reg);

        t1   = 32'd3 * 32'(kin_reg) * 32'(s_reg);
        t2   = 32'd4 * (32'd120 - 32'(kin_reg)) * (32'(s_reg) - 32'(g_reg));
        prod = $signed(it_reg.amount) * $signed({1'b0, num_reg});
        pmag = prod[63] ? 64'(-prod) : 64'(prod);
        amag = a_reg[31] ? 32'(-a_reg) : 32'(a_reg);
        left = $signed({1'b0, dur_reg}) - $signed({1'b0, age_reg});
        due_sum = 33'(due_reg) + 33'(dv_quot);
        rest = a_reg - pay_reg;
        age1 = 17'(age_reg) + 17'd1;
        acc_add = acc_reg + ACC_W'(pay_reg);

        ram_wdata = {rest, age1[15:0]};

        // one divider step in either divide state
        if ((st_reg == ST_DIVF || st_reg == ST_DIVT) && dc_reg != 7'd0)
        begin
            dn_next = {dn_reg[62:0], 1'b0};
            dc_next = dc_reg - 7'd1;
            if (!dv_diff[32])
            begin
                dr_next = dv_diff[31:0];
                dq_next = {dq_reg[30:0], 1'b1};
            end
            else
            begin
                dr_next = dv_sh[31:0];
                dq_next = {dq_reg[30:0], 1'b0};
            end
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    it_next = in_data;
                    if (in_data.action == ACT_TICK)
                    begin
                        acc_next = ACC_W'(due_reg);
                        due_next = '0;
                        i_next   = '0;
                        w_next   = '0;
                        if (dur_reg == 16'd0 || cnt_reg == '0)
                        begin
                            st_next = ST_FIN;
                        end
                        else
                        begin
                            st_next = ST_RD;
                        end
                    end
                    else
                    begin
                        st_next = ST_SC1;
                    end
                end
            end
            ST_SC1:
            begin
                s_next  = S_W'(32'(rcv_reg) * 32'(SLOW_WINDOW_TICKS));
                g_next  = 23'(it_reg.gap_ticks) * 23'd120;
                st_next = ST_SC2;
            end
            ST_SC2:
            begin
                if (kin_reg >= 8'd120)
                begin
                    num_next = NUM_W'(1);
                    den_next = NUM_W'(1);
                end
                else if (it_reg.first_event || s_reg == '0 || 32'(g_reg) >= 32'(s_reg))
                begin
                    num_next = NUM_W'(kin_reg);
                    den_next = NUM_W'(120);
                end
                else if (32'(g_reg) * 32'd4 <= 32'(s_reg))
                begin
                    num_next = NUM_W'(1);
                    den_next = NUM_W'(1);
                end
                else
                begin
                    num_next = NUM_W'(t1 + t2);
                    den_next = NUM_W'(32'(s_reg) * 32'd360);
                end
                st_next = ST_SC3;
            end
            ST_SC3:
            begin
                dn_next   = pmag;
                dd_next   = 32'(den_reg);
                dr_next   = '0;
                dq_next   = '0;
                dc_next   = 7'd64;
                dneg_next = prod[63];
                st_next   = ST_DIVF;
            end
            ST_DIVF:
            begin
                if (dc_reg == 7'd0)
                begin
                    st_next = ST_IDLE;
                    if (dv_quot != 32'sd0)
                    begin
                        if (dur_reg == 16'd0 || cnt_reg == CW'(ENTRIES))
                        begin
                            if (due_sum > 33'sd2147483647)
                            begin
                                due_next = 32'sh7fffffff;
                            end
                            else if (due_sum < -33'sd2147483648)
                            begin
                                due_next = 32'sh80000000;
                            end
                            else
                            begin
                                due_next = due_sum[31:0];
                            end
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cnt_reg[AW-1:0];
                            ram_wdata = {dv_quot, 16'd0};
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                end
            end
            ST_RD:
            begin
                ram_re  = 1'b1;
                st_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                a_next   = ram_rdata[47:16];
                age_next = ram_rdata[15:0];
                pay_next = ram_rdata[47:16];
                // left is formed from the latched entry next cycle, so branch there
                st_next  = ST_DIVT;
                dc_next  = 7'd0;
                dd_next  = '0;
                dn_next  = '0;
            end
            ST_DIVT:
            begin
                if (dc_reg == 7'd0 && dn_reg[0] == 1'b0 && dd_reg == 32'd0)
                begin
                    // first cycle after eval: set up the divide or skip it
                    if (left > 17'sd1)
                    begin
                        dn_next   = {amag, 32'd0};
                        dd_next   = 32'(left[15:0]);
                        dr_next   = '0;
                        dq_next   = '0;
                        dc_next   = 7'd32;
                        dneg_next = a_reg[31];
                    end
                    else
                    begin
                        pay_next = a_reg;
                        st_next  = ST_APPLY;
                    end
                end
                else if (dc_reg == 7'd0)
                begin
                    pay_next = dv_quot;
                    dd_next  = '0;
                    dn_next  = '0;
                    st_next  = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                acc_next = acc_add;
                if (32'(age1) < 32'(dur_reg) && rest != 32'sd0)
                begin
                    ram_we = 1'b1;
                    w_next = w_reg + CW'(1);
                end
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) == cnt_reg)
                begin
                    st_next = ST_FIN;
                end
                else
                begin
                    st_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cnt_next = w_reg;
                    ov_next  = 1'b1;
                    if (acc_reg > ACC_W'(32'sh7fffffff))
                    begin
                        od_next.paid = 32'sh7fffffff;
                    end
                    else if (acc_reg < -ACC_W'(33'sh080000000))
                    begin
                        od_next.paid = 32'sh80000000;
                    end
                    else
                    begin
                        od_next.paid = acc_reg[31:0];
                    end
                    od_next.active = (w_reg != '0);
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
            i_reg   <= '0;
            w_reg   <= '0;
            due_reg <= '0;
            acc_reg <= '0;
            ov_reg  <= 1'b0;
            dc_reg  <= '0;
            dd_reg  <= '0;
            dn_reg  <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            i_reg   <= i_next;
            w_reg   <= w_next;
            due_reg <= due_next;
            acc_reg <= acc_next;
            ov_reg  <= ov_next;
            dc_reg  <= dc_next;
            dd_reg  <= dd_next;
            dn_reg  <= dn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg   <= od_next;
        it_reg   <= it_next;
        s_reg    <= s_next;
        g_reg    <= g_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        a_reg    <= a_next;
        age_reg  <= age_next;
        pay_reg  <= pay_next;
        dr_reg   <= dr_next;
        dq_reg   <= dq_next;
        dneg_reg <= dneg_next;
    end
endmodule
